### sv/trr_pkg.sv
// ----------------------------------------------------------------------------
// trr_pkg: shared types and constants for the trace record ring
// Record layout, opcodes, ASCII codes and the line formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package trr_pkg;

    localparam int MAX_DEPTH        = 1024;
    localparam int ADDR_W           = $clog2(MAX_DEPTH);
    localparam int CNT_W            = ADDR_W + 1;
    localparam int DEPTH_LOG2_W     = 4;
    localparam int LINE_CHARS       = 64;
    localparam int CHAR_IDX_W       = $clog2(LINE_CHARS);

    localparam logic [DEPTH_LOG2_W-1:0] DEPTH_LOG2_MAX   = DEPTH_LOG2_W'(ADDR_W);
    localparam logic [DEPTH_LOG2_W-1:0] DEPTH_LOG2_RESET = DEPTH_LOG2_W'(10);
    localparam logic [CHAR_IDX_W-1:0]   CHAR_IDX_LAST    = CHAR_IDX_W'(LINE_CHARS - 1);

    // operation codes
    localparam logic [1:0] OP_ENTRY = 2'd0;
    localparam logic [1:0] OP_EXIT  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // ASCII
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] CH_X    = 8'h58;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_A_10 = 8'h37;   // 'A' - 10
    localparam logic [7:0] CH_NUL  = 8'h00;

    typedef struct packed {
        logic        kind;     // 1 = exit
        logic [31:0] pc;
        logic [63:0] ts;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    // controller -> datapath
    typedef struct packed {
        logic store;       // write event into ring
        logic fetch;       // read oldest record, pop
        logic emit_char;   // load next character into output register
        logic emit_empty;  // load empty result into output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic out_free;
        logic last_char;
    } stat_t;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10)
            c = CH_ZERO + {4'h0, n};
        else
            c = CH_A_10 + {4'h0, n};
        return c;
    endfunction

    // character p of the formatted line for record r
    function automatic logic [7:0] char_at(input rec_t r, input logic [CHAR_IDX_W-1:0] p);
        logic [5:0] i;
        logic [7:0] ch;
        i  = 6'd0;
        ch = CH_SP;
        priority if (p == 6'd0)
        begin
            ch = r.kind ? CH_X : CH_E;
        end
        else if (p >= 6'd2 && p <= 6'd9)
        begin
            i  = 6'd9 - p;
            ch = hex_char(r.pc[{i[2:0], 2'b00} +: 4]);
        end
        else if (p >= 6'd11 && p <= 6'd26)
        begin
            i  = 6'd26 - p;
            ch = hex_char(r.ts[{i[3:0], 2'b00} +: 4]);
        end
        else if (p >= 6'd28 && p <= 6'd35)
        begin
            i  = 6'd35 - p;
            ch = hex_char(r.w0[{i[2:0], 2'b00} +: 4]);
        end
        else if (p >= 6'd37 && p <= 6'd44)
        begin
            i  = 6'd44 - p;
            ch = hex_char(r.w1[{i[2:0], 2'b00} +: 4]);
        end
        else if (p >= 6'd46 && p <= 6'd53)
        begin
            i  = 6'd53 - p;
            ch = hex_char(r.w2[{i[2:0], 2'b00} +: 4]);
        end
        else if (p >= 6'd55 && p <= 6'd62)
        begin
            i  = 6'd62 - p;
            ch = hex_char(r.w3[{i[2:0], 2'b00} +: 4]);
        end
        else if (p == CHAR_IDX_LAST)
        begin
            ch = CH_NL;
        end
        else
        begin
            ch = CH_SP;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

### sv/trr_if.sv
// ----------------------------------------------------------------------------
// trr_if: word channels of the trace record ring
// Event/read request channel and character result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface trr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] pc;
    logic [63:0] timestamp;
    logic [31:0] arg0;
    logic [31:0] arg1;
    logic [31:0] arg2;
    logic [31:0] arg3;

    modport source (output valid, operation, pc, timestamp, arg0, arg1, arg2, arg3,
                    input ready);
    modport sink   (input valid, operation, pc, timestamp, arg0, arg1, arg2, arg3,
                    output ready);
endinterface

interface trr_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last;
    logic       empty_res;

    modport source (output valid, text_char, last, empty_res, input ready);
    modport sink   (input valid, text_char, last, empty_res, output ready);
endinterface

`default_nettype wire

### sv/trr_ram.sv
// ----------------------------------------------------------------------------
// trr_ram: generic single-port-write, single-port-read RAM
// Registered read; read data holds while rd_en is low.
// ----------------------------------------------------------------------------
`default_nettype none

module trr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### sv/trr_ctrl.sv
// ----------------------------------------------------------------------------
// trr_ctrl: controller of the trace record ring
// Sequences event capture, record fetch and character emission.
// ----------------------------------------------------------------------------
`default_nettype none

module trr_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    input  wire logic [1:0]     req_op,
    output logic                req_ready,
    input  wire trr_pkg::stat_t stat,
    output trr_pkg::cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,    // RAM read in flight
        ST_EMIT,
        ST_EMPTY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take;

    assign req_ready = (state_reg == ST_IDLE);
    assign take      = req_valid && req_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if ((req_op == trr_pkg::OP_ENTRY || req_op == trr_pkg::OP_EXIT)
                        && !stat.full)
                        cmd.store = 1'b1;
                    else if (req_op == trr_pkg::OP_READ)
                    begin
                        if (stat.empty)
                            state_next = ST_EMPTY;
                        else
                        begin
                            cmd.fetch  = 1'b1;
                            state_next = ST_WAIT;
                        end
                    end
                end
            end
            ST_WAIT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_char = 1'b1;
                    if (stat.last_char)
                        state_next = ST_IDLE;
                end
            end
            ST_EMPTY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

### sv/trr_dp.sv
// ----------------------------------------------------------------------------
// trr_dp: datapath of the trace record ring
// Ring counters, record RAM, line formatter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module trr_dp (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [trr_pkg::DEPTH_LOG2_W-1:0]     cfg_wr_data,
    input  wire logic [1:0]                           op,
    input  wire logic [31:0]                          pc,
    input  wire logic [63:0]                          timestamp,
    input  wire logic [31:0]                          arg0,
    input  wire logic [31:0]                          arg1,
    input  wire logic [31:0]                          arg2,
    input  wire logic [31:0]                          arg3,
    input  wire trr_pkg::cmd_t                        cmd,
    output trr_pkg::stat_t                            stat,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [7:0]                                out_char,
    output logic                                      out_last,
    output logic                                      out_empty
);

    logic [trr_pkg::DEPTH_LOG2_W-1:0] depth_log2_reg;
    logic [trr_pkg::DEPTH_LOG2_W-1:0] depth_log2_eff;
    logic [trr_pkg::CNT_W-1:0]        depth;
    logic [trr_pkg::ADDR_W-1:0]       mask;
    logic [trr_pkg::CNT_W-1:0]        wr_cnt_reg, wr_cnt_next;
    logic [trr_pkg::CNT_W-1:0]        rd_cnt_reg, rd_cnt_next;
    logic [trr_pkg::CNT_W-1:0]        fill;
    logic [trr_pkg::CHAR_IDX_W-1:0]   idx_reg, idx_next;
    logic                             out_valid_reg, out_valid_next;
    logic [7:0]                       char_reg, char_next;
    logic                             last_reg, last_next;
    logic                             empty_reg, empty_next;
    trr_pkg::rec_t                    wr_rec;
    trr_pkg::rec_t                    rd_rec;
    logic [trr_pkg::REC_W-1:0]        rd_data;
    logic                             is_exit;

    // saturate depth to what the RAM holds
    assign depth_log2_eff = (depth_log2_reg > trr_pkg::DEPTH_LOG2_MAX)
                          ? trr_pkg::DEPTH_LOG2_MAX : depth_log2_reg;
    assign depth = trr_pkg::CNT_W'(1) << depth_log2_eff;
    assign mask  = trr_pkg::ADDR_W'(depth - trr_pkg::CNT_W'(1));
    assign fill  = wr_cnt_reg - rd_cnt_reg;

    assign stat.full      = (fill >= depth);
    assign stat.empty     = (fill == '0);
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.last_char = (idx_reg == trr_pkg::CHAR_IDX_LAST);

    // exit records keep the return value only
    assign is_exit   = (op == trr_pkg::OP_EXIT);
    assign wr_rec.kind = is_exit;
    assign wr_rec.pc   = pc;
    assign wr_rec.ts   = timestamp;
    assign wr_rec.w0   = arg0;
    assign wr_rec.w1   = is_exit ? 32'd0 : arg1;
    assign wr_rec.w2   = is_exit ? 32'd0 : arg2;
    assign wr_rec.w3   = is_exit ? 32'd0 : arg3;

    trr_ram #(
        .WIDTH (trr_pkg::REC_W),
        .DEPTH (trr_pkg::MAX_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.store),
        .wr_addr (wr_cnt_reg[trr_pkg::ADDR_W-1:0] & mask),
        .wr_data (wr_rec),
        .rd_en   (cmd.fetch),
        .rd_addr (rd_cnt_reg[trr_pkg::ADDR_W-1:0] & mask),
        .rd_data (rd_data)
    );

    assign rd_rec = trr_pkg::rec_t'(rd_data);

    always_comb
    begin
        wr_cnt_next = wr_cnt_reg;
        rd_cnt_next = rd_cnt_reg;
        if (cfg_wr_en)
        begin
            wr_cnt_next = '0;
            rd_cnt_next = '0;
        end
        else
        begin
            if (cmd.store)
                wr_cnt_next = wr_cnt_reg + trr_pkg::CNT_W'(1);
            if (cmd.fetch)
                rd_cnt_next = rd_cnt_reg + trr_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.fetch)
            idx_next = '0;
        if (cmd.emit_char)
        begin
            idx_next       = idx_reg + trr_pkg::CHAR_IDX_W'(1);
            out_valid_next = 1'b1;
            char_next      = trr_pkg::char_at(rd_rec, idx_reg);
            last_next      = (idx_reg == trr_pkg::CHAR_IDX_LAST);
            empty_next     = 1'b0;
        end
        else if (cmd.emit_empty)
        begin
            out_valid_next = 1'b1;
            char_next      = trr_pkg::CH_NUL;
            last_next      = 1'b1;
            empty_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_log2_reg <= trr_pkg::DEPTH_LOG2_RESET;
            wr_cnt_reg     <= '0;
            rd_cnt_reg     <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                depth_log2_reg <= cfg_wr_data;
            wr_cnt_reg    <= wr_cnt_next;
            rd_cnt_reg    <= rd_cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg  <= char_next;
        last_reg  <= last_next;
        empty_reg <= empty_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;
    assign out_empty = empty_reg;

endmodule

`default_nettype wire

### sv/trace_record_ring_with_hex_dump.sv
// ----------------------------------------------------------------------------
// trace_record_ring_with_hex_dump: trace capture ring with text read-out
// Stores entry/exit events in a ring; a read pops one record as 64 ASCII chars.
// ----------------------------------------------------------------------------
//
//  channel | dir | word                                        | accepted when
//  --------+-----+---------------------------------------------+-----------------
//  req     | in  | operation, pc, timestamp, arg0..arg3        | valid && ready
//  rsp     | out | text_char, last, empty_res                  | valid && ready
//  cfg     | in  | cfg_wr_data = depth_log2 (4 bits)           | cfg_wr_en
//
//  - Entry/exit event: taken back to back while idle; dropped silently when full.
//  - Read: the accept fetches the record from RAM, a wait state covers the read,
//    then one char per cycle into the output register while rsp does not stall.
//  - Empty read: one word (NUL, last, empty_res).
//  - rsp stalls hold the output register; req.ready is low until the final
//    char is loaded, so events may be taken while the newline still waits.
//  - Reset: counts cleared, depth_log2 = 10. Record RAM is not cleared
//    (only slots below the write count are ever read).
// ----------------------------------------------------------------------------
`default_nettype none

module trace_record_ring_with_hex_dump (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [trr_pkg::DEPTH_LOG2_W-1:0] cfg_wr_data,
    trr_req_if.sink                               req,
    trr_rsp_if.source                             rsp
);

    trr_pkg::cmd_t  cmd;
    trr_pkg::stat_t stat;

    // controller: state machine, decides what happens to each word
    trr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.operation),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: counters, record RAM, formatter, output register
    trr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .op          (req.operation),
        .pc          (req.pc),
        .timestamp   (req.timestamp),
        .arg0        (req.arg0),
        .arg1        (req.arg1),
        .arg2        (req.arg2),
        .arg3        (req.arg3),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .out_char    (rsp.text_char),
        .out_last    (rsp.last),
        .out_empty   (rsp.empty_res)
    );

endmodule

`default_nettype wire

### sv/trr_checker.sv
// ----------------------------------------------------------------------------
// trr_checker: port-level checks for the trace record ring
// Bound to the top level; watches the req and rsp channels only.
// ----------------------------------------------------------------------------
`default_nettype none

module trr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_ready,
    input wire logic [1:0] req_operation,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [7:0] rsp_text_char,
    input wire logic       rsp_last,
    input wire logic       rsp_empty_res
);

    // a read blocks the request side for at least the next cycle
    a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_operation == trr_pkg::OP_READ |=> !req_ready)
        else $error("request taken right after a read");

    // mid-line characters never overlap with request acceptance
    a_line_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> !req_ready)
        else $error("request ready while a line is being emitted");

    // empty result is a lone NUL word marked last
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_empty_res |-> rsp_last && rsp_text_char == trr_pkg::CH_NUL)
        else $error("malformed empty result");

    // stalled word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_text_char)
                                    && $stable(rsp_last))
        else $error("rsp word changed under stall");

endmodule

bind trace_record_ring_with_hex_dump trr_checker u_trr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_operation (req.operation),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_text_char (rsp.text_char),
    .rsp_last      (rsp.last),
    .rsp_empty_res (rsp.empty_res)
);

`default_nettype wire

### tb/trace_ring_checker.sv
// ----------------------------------------------------------------------------
// trace_ring_checker: record ring predictor and text line scoreboard
// Watches the request, result and configuration ports. It keeps its own copy
// of the ring, builds the expected text line for every read, and compares each
// result word with the oldest expected character.
// ----------------------------------------------------------------------------
module trace_ring_checker
    import trr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [DEPTH_LOG2_W-1:0] cfg_wr_data,
    trr_req_if                      req,
    trr_rsp_if                      rsp,
    output int                      fail_count,
    output int                      pending_chars
);

    typedef struct packed {
        logic [7:0] text_char;
        logic       last;
        logic       empty_res;
    } line_char_t;

    line_char_t char_q [$];

    // own copy of the ring
    logic              kind_mem [MAX_DEPTH];
    logic [31:0]       pc_mem   [MAX_DEPTH];
    logic [63:0]       ts_mem   [MAX_DEPTH];
    logic [31:0]       arg_mem  [MAX_DEPTH][4];
    logic [CNT_W-1:0]  wr_count  = '0;
    logic [CNT_W-1:0]  rd_count  = '0;
    logic [DEPTH_LOG2_W-1:0] depth_sel = DEPTH_LOG2_RESET;

    int errors  = 0;
    int waiting = 0;

    assign fail_count    = errors;
    assign pending_chars = waiting;

    // settings above the largest ring saturate
    function automatic int ring_slots(input logic [DEPTH_LOG2_W-1:0] d);
        int n;
        n = (d > DEPTH_LOG2_MAX) ? MAX_DEPTH : (1 << d);
        return n;
    endfunction

    function automatic logic [7:0] hex_glyph(input logic [3:0] n);
        logic [7:0] g;
        g = (n < 4'd10) ? 8'h30 + 8'(n) : 8'h41 + 8'(n) - 8'd10;
        return g;
    endfunction

    task automatic push_char(input logic [7:0] c, input logic fin);
        char_q.push_back('{c, fin, 1'b0});
    endtask

    task automatic push_hex(input logic [63:0] v, input int digits);
        for (int i = digits - 1; i >= 0; i--)
            push_char(hex_glyph(v[4*i +: 4]), 1'b0);
    endtask

    task automatic capture_event();
        int               slots;
        int               slot;
        logic [CNT_W-1:0] fill;
        logic             is_exit;
        slots   = ring_slots(depth_sel);
        fill    = wr_count - rd_count;
        is_exit = (req.operation == OP_EXIT);
        if (fill >= slots)
            return;   // full: dropped
        slot = int'(wr_count) & (slots - 1);
        kind_mem[slot]   = is_exit;
        pc_mem[slot]     = req.pc;
        ts_mem[slot]     = req.timestamp;
        arg_mem[slot][0] = req.arg0;
        arg_mem[slot][1] = is_exit ? 32'd0 : req.arg1;
        arg_mem[slot][2] = is_exit ? 32'd0 : req.arg2;
        arg_mem[slot][3] = is_exit ? 32'd0 : req.arg3;
        wr_count = wr_count + 1'b1;
    endtask

    task automatic emit_record();
        int               slots;
        int               slot;
        logic [CNT_W-1:0] fill;
        slots = ring_slots(depth_sel);
        fill  = wr_count - rd_count;
        if (fill == '0)
        begin
            char_q.push_back('{CH_NUL, 1'b1, 1'b1});
            return;
        end
        slot = int'(rd_count) & (slots - 1);
        push_char(kind_mem[slot] ? CH_X : CH_E, 1'b0);
        push_char(CH_SP, 1'b0);
        push_hex({32'd0, pc_mem[slot]}, 8);
        push_char(CH_SP, 1'b0);
        push_hex(ts_mem[slot], 16);
        push_char(CH_SP, 1'b0);
        for (int j = 0; j < 4; j++)
        begin
            push_hex({32'd0, arg_mem[slot][j]}, 8);
            push_char((j == 3) ? CH_NL : CH_SP, j == 3);
        end
        rd_count = rd_count + 1'b1;
    endtask

    task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %02h, actual %02h", $time, what, want, got);
        end
    endtask

    task automatic compare_char();
        line_char_t want;
        if (char_q.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected word: expected none, actual char %02h last %b empty %b",
                     $time, rsp.text_char, rsp.last, rsp.empty_res);
            return;
        end
        want = char_q.pop_front();
        check_field("text_char", want.text_char, rsp.text_char);
        check_field("last", {7'd0, want.last}, {7'd0, rsp.last});
        check_field("empty_res", {7'd0, want.empty_res}, {7'd0, rsp.empty_res});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_count  = '0;
            rd_count  = '0;
            depth_sel = DEPTH_LOG2_RESET;
            char_q.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                compare_char();
            if (cfg_wr_en)
            begin
                depth_sel = cfg_wr_data;
                wr_count  = '0;
                rd_count  = '0;
            end
            if (req.valid && req.ready)
            begin
                if (req.operation == OP_ENTRY || req.operation == OP_EXIT)
                    capture_event();
                else if (req.operation == OP_READ)
                    emit_record();
            end
        end
        waiting = char_q.size();
    end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: trace record ring with hex dump, top level
// Drives entry, exit and read words plus depth settings, and paces the result
// side; a checker beside the block predicts every text line and compares it.
// ----------------------------------------------------------------------------
module testbench;
    import trr_pkg::*;

    // operation code that the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int PHASE_ITEMS = 30;      // random words per depth setting
    localparam int LONG_HOLD   = 300;     // receiver hold-off, in cycles
    localparam int DRAIN       = 12;      // settle time once no line is due

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [DEPTH_LOG2_W-1:0] cfg_wr_data;

    int fail_count;
    int pending_chars;

    // idle odds in percent, changed per phase
    int send_idle = 9;
    int recv_idle = 51;

    // raised by the stimulus, taken by the receiver for one long hold-off
    bit hold_off_req = 1'b0;

    trr_req_if req_ch ();
    trr_rsp_if rsp_ch ();

    trace_record_ring_with_hex_dump u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    trace_ring_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fail_count    (fail_count),
        .pending_chars (pending_chars)
    );

    // 10 unit period
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Generous ceiling on the run time.
    initial
    begin
        #5000000;
        $display("testbench failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure, or one long hold-off on request.
    // The hold-off is counted here so the sender keeps offering words
    // while the output register sits full.
    // ------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // mostly random, with the odd all-zero or all-ones word
    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        case ($urandom_range(7))
            0:       w = 32'h0000_0000;
            1:       w = 32'hFFFF_FFFF;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Offers one word and returns at the falling edge after it is taken.
    // valid stays high; the next call or stop_requests decides what follows,
    // so valid never drops and rises within one time step.
    task automatic put_word(input logic [1:0] op, input logic [31:0] pc,
                            input logic [63:0] ts, input logic [31:0] a0,
                            input logic [31:0] a1, input logic [31:0] a2,
                            input logic [31:0] a3);
        while ($urandom_range(99) < send_idle)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.pc        <= pc;
        req_ch.timestamp <= ts;
        req_ch.arg0      <= a0;
        req_ch.arg1      <= a1;
        req_ch.arg2      <= a2;
        req_ch.arg3      <= a3;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic put_random(input logic [1:0] op);
        put_word(op, rand_word(), {rand_word(), rand_word()},
                 rand_word(), rand_word(), rand_word(), rand_word());
    endtask

    task automatic put_event();
        put_random($urandom_range(1) ? OP_EXIT : OP_ENTRY);
    endtask

    task automatic stop_requests();
        req_ch.valid <= 1'b0;
    endtask

    // Block is idle once no character is due and events have had time to land.
    task automatic wait_idle();
        stop_requests();
        while (pending_chars != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    // Depth writes empty the ring, so only ever done while idle.
    task automatic set_depth(input logic [DEPTH_LOG2_W-1:0] d);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= d;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    // Depth per random phase: small rings to hit the drop path, saturated
    // settings above the largest ring, and both extremes.
    function automatic logic [DEPTH_LOG2_W-1:0] phase_depth(input int p);
        logic [DEPTH_LOG2_W-1:0] d;
        case (p)
            0:       d = 4'd2;
            1:       d = 4'd0;
            2:       d = 4'd15;
            3:       d = 4'd1;
            4:       d = 4'd10;
            5:       d = 4'd11;
            6:       d = 4'd3;
            default: d = 4'd4;
        endcase
        return d;
    endfunction

    // A run of events then a run of reads; reads past the fill level give
    // empty results. Now and then an ignored opcode slips in.
    task automatic run_burst(input logic [DEPTH_LOG2_W-1:0] d, inout int done);
        int n_ev;
        int n_rd;
        n_ev = $urandom_range((d < 3) ? (2 << d) + 1 : 8);
        for (int k = 0; k < n_ev; k++)
        begin
            if ($urandom_range(15) == 0)
                put_random(OP_UNUSED);
            else
            begin
                put_event();
                done++;
            end
        end
        n_rd = $urandom_range(n_ev + 1);
        for (int k = 0; k < n_rd; k++)
        begin
            put_random(OP_READ);
            done++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int done;
        logic [DEPTH_LOG2_W-1:0] d;

        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_ENTRY;
        req_ch.pc        = '0;
        req_ch.timestamp = '0;
        req_ch.arg0      = '0;
        req_ch.arg1      = '0;
        req_ch.arg2      = '0;
        req_ch.arg3      = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed, at the reset depth ---
        // read of an empty ring
        put_word(OP_READ, '0, '0, '0, '0, '0, '0);
        // all ones, entry then exit (exit keeps only the return value)
        put_word(OP_ENTRY, '1, '1, '1, '1, '1, '1);
        put_word(OP_EXIT, '1, '1, '1, '1, '1, '1);
        put_word(OP_ENTRY, '0, '0, '0, '0, '0, '0);
        // every hex digit shows up
        put_word(OP_ENTRY, 32'h0123_4567, 64'h89AB_CDEF_FEDC_BA98,
                 32'h7654_3210, 32'hA5A5_5A5A, 32'hC3C3_3C3C, 32'h0F0F_F0F0);
        put_word(OP_EXIT, 32'hDEAD_BEEF, 64'h0000_0001_0000_0000,
                 32'hCAFE_F00D, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333);
        // ignored opcode: no line, no change
        put_word(OP_UNUSED, '1, '1, '1, '1, '1, '1);
        // drain all five records, then one more gives an empty word
        repeat (6) put_random(OP_READ);

        // one-slot ring: second event is dropped
        set_depth(4'd0);
        put_word(OP_ENTRY, 32'h0000_1000, 64'd7, 32'd1, 32'd2, 32'd3, 32'd4);
        put_word(OP_EXIT, 32'h0000_2000, 64'd8, 32'd9, 32'd9, 32'd9, 32'd9);
        put_random(OP_READ);
        put_random(OP_READ);

        // setting above the largest ring saturates
        set_depth(4'd15);
        put_event();
        put_random(OP_READ);

        // --- random phases ---
        for (int p = 0; p < 8; p++)
        begin
            d = phase_depth(p);
            set_depth(d);
            // first three phases: sender busy, receiver slow; then the reverse;
            // the last two run flat out
            if (p < 3)
            begin
                send_idle = 9;
                recv_idle = 51;
            end
            else if (p < 6)
            begin
                send_idle = 51;
                recv_idle = 9;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            done = 0;
            if (p == 6)
            begin
                // long receiver hold-off: the first read parks a character in
                // the output register, the request side stalls, and further
                // events find the ring full
                hold_off_req = 1'b1;
                repeat (10) put_event();
                repeat (3) put_random(OP_READ);
                repeat (4) put_event();
                done += 17;
            end
            while (done < PHASE_ITEMS)
                run_burst(d, done);
        end

        // --- end of run ---
        stop_requests();
        while (pending_chars != 0) @(negedge clk);
        repeat (80) @(negedge clk);
        if (fail_count == 0 && pending_chars == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

### trace_record_ring_with_hex_dump.f
sv/trr_pkg.sv
sv/trr_if.sv
sv/trr_ram.sv
sv/trr_ctrl.sv
sv/trr_dp.sv
sv/trace_record_ring_with_hex_dump.sv
sv/trr_checker.sv
tb/trace_ring_checker.sv
tb/testbench.sv
